>>> rtl/core/fcb_pkg.sv
// Shared types, constants and helper functions of the force compensated balance block.
`default_nettype none

package fcb_pkg;

  localparam int AVG_WINDOW_DEF = 100;
  localparam int SUM_W          = 44;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_ADDR_W     = 5;
  localparam int CORDIC_STEPS   = 17;

  localparam logic [19:0]        G_Q16       = 20'd642908;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [19:0] PI_Q16      = 20'sd205887;

  typedef enum logic [2:0] {
    REG_TOTAL_MASS     = 3'd0,
    REG_FORCE_DEADBAND = 3'd1,
    REG_GAIN_KP        = 3'd2,
    REG_GAIN_KD        = 3'd3,
    REG_DRIVE_LIMIT    = 3'd4,
    REG_WHEEL_RADIUS   = 3'd5,
    REG_COM_X_OFFSET   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [30:0]        total_mass;
    logic [30:0]        force_deadband;
    logic [30:0]        gain_kp;
    logic [30:0]        gain_kd;
    logic [30:0]        drive_limit;
    logic [30:0]        wheel_radius;
    logic signed [31:0] com_x_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] torque_sum;
    logic signed [31:0]      com_x;
    logic signed [31:0]      com_z;
    logic signed [31:0]      pitch_rate;
    logic                    respond;
    logic                    balance;
  } q_entry_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [16:0] atan_entry(input logic [4:0] i);
    logic [16:0] r;
    unique case (i)
      5'd0:    r = 17'd51472;
      5'd1:    r = 17'd30385;
      5'd2:    r = 17'd16055;
      5'd3:    r = 17'd8150;
      5'd4:    r = 17'd4091;
      5'd5:    r = 17'd2047;
      5'd6:    r = 17'd1024;
      5'd7:    r = 17'd512;
      5'd8:    r = 17'd256;
      5'd9:    r = 17'd128;
      5'd10:   r = 17'd64;
      5'd11:   r = 17'd32;
      5'd12:   r = 17'd16;
      5'd13:   r = 17'd8;
      5'd14:   r = 17'd4;
      5'd15:   r = 17'd2;
      5'd16:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/fcb_front.sv
// Front end: accepts items, applies the deadband, forms the torque and updates the moving sum.
`default_nettype none

module fcb_front #(
  parameter int AVG_WINDOW = fcb_pkg::AVG_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fcb_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_z,
  input  logic signed [31:0] gripper_x,
  input  logic signed [31:0] gripper_z,
  input  logic signed [31:0] com_x_raw,
  input  logic signed [31:0] com_z_raw,
  input  logic signed [31:0] pitch_rate,
  input  logic               respond,
  input  logic               balance,
  output logic               q_push,
  output fcb_pkg::q_entry_t  q_data,
  input  logic               q_full
);
  import fcb_pkg::*;

  localparam int PTR_W = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int CNT_W = $clog2(AVG_WINDOW + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(AVG_WINDOW - 1);
  localparam logic [PTR_W-1:0] PTR_START = PTR_W'(1 % AVG_WINDOW);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(AVG_WINDOW - 1);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL1 = 5'b00010,
    F_MUL2 = 5'b00100,
    F_TORQ = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t                 state_r, state_nxt;
  logic [PTR_W-1:0]        ptr_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    full_r;
  logic signed [SUM_W-1:0] sum_r;

  logic signed [31:0] fx_r, fz_r, gx_r, lever_r, cx_r, cz_r, rate_r;
  logic               respond_r, balance_r;
  logic signed [63:0] prod_r;
  logic signed [47:0] t1_r;
  logic signed [31:0] hist_rd_r;
  logic signed [31:0] hist_mem [AVG_WINDOW];

  logic               accept;
  logic               mem_we;
  logic signed [31:0] torque;
  logic signed [31:0] old_val;
  logic signed [31:0] wr_s;
  logic               fx_keep, fz_keep;

  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = 33'(v);
    return v[31] ? $unsigned(-e) : $unsigned(e);
  endfunction

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;
  assign mem_we   = (state_r == F_TORQ);
  assign wr_s     = $signed({1'b0, cfg.wheel_radius});
  assign fx_keep  = mag33(force_x) > {2'b00, cfg.force_deadband};
  assign fz_keep  = mag33(force_z) > {2'b00, cfg.force_deadband};
  assign torque   = sat32(66'(t1_r) + 66'(prod_r >>> 16));
  assign old_val  = full_r ? hist_rd_r : 32'sd0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_MUL1;
      F_MUL1:  state_nxt = F_MUL2;
      F_MUL2:  state_nxt = F_TORQ;
      F_TORQ:  state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      ptr_r   <= PTR_START;
      cnt_r   <= '0;
      full_r  <= 1'b0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        sum_r <= sum_r + SUM_W'(torque) - SUM_W'(old_val);
        ptr_r <= (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
        if (!full_r) begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) full_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fx_r      <= fx_keep ? force_x : 32'sd0;
      fz_r      <= fz_keep ? force_z : 32'sd0;
      gx_r      <= gripper_x;
      lever_r   <= sat32(66'(gripper_z) - 66'(wr_s));
      cx_r      <= sat32(66'(com_x_raw) + 66'(cfg.com_x_offset));
      cz_r      <= sat32(66'(com_z_raw) - 66'(wr_s));
      rate_r    <= pitch_rate;
      respond_r <= respond;
      balance_r <= balance;
    end
    if (state_r == F_MUL1) prod_r <= fx_r * lever_r;
    if (state_r == F_MUL2) begin
      t1_r   <= 48'(prod_r >>> 16);
      prod_r <= fz_r * gx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[ptr_r] <= torque;
    if (accept) hist_rd_r <= hist_mem[ptr_r];
  end

  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_data = '{torque_sum: sum_r, com_x: cx_r, com_z: cz_r, pitch_rate: rate_r,
                    respond: respond_r, balance: balance_r};

endmodule

`default_nettype wire

>>> rtl/core/fcb_queue.sv
// Short queue of classified items between the front end and the back end.
`default_nettype none

module fcb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fcb_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output fcb_pkg::q_entry_t pop_data,
  output logic              empty
);
  import fcb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PW-1:0] PTR_LAST  = PW'(QUEUE_DEPTH - 1);
  localparam logic [PW:0]   CNT_DEPTH = (PW + 1)'(QUEUE_DEPTH);

  q_entry_t      slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full     = (count_r == CNT_DEPTH);
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

>>> rtl/core/fcb_back.sv
// Back end: sequencer with shared multiplier, divider, square root and CORDIC for the PD law.
`default_nettype none

module fcb_back #(
  parameter int AVG_WINDOW = fcb_pkg::AVG_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fcb_pkg::cfg_t      cfg,
  input  logic               q_empty,
  output logic               q_pop,
  input  fcb_pkg::q_entry_t  q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] motor_current,
  output logic               drive_enable,
  output logic signed [18:0] reference_angle,
  output logic signed [18:0] tilt_angle
);
  import fcb_pkg::*;

  localparam int NUM_W = 48;
  localparam int DEN_W = 36;
  localparam int RECIP_SH = 52;
  localparam logic [63:0] RECIP =
    ((64'd1 << RECIP_SH) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW);
  localparam logic [25:0] RECIP_LO = RECIP[25:0];
  localparam logic [26:0] RECIP_HI = RECIP[52:26];
  localparam logic [5:0] AVG_LAST  = 6'd4;
  localparam logic [5:0] DIV_LAST  = 6'(NUM_W - 1);
  localparam logic [5:0] ROOT_LAST = 6'd31;
  localparam logic [5:0] ROT_LAST  = 6'(CORDIC_STEPS - 1);
  localparam logic signed [35:0] NORM_LIM = 36'sd536870912;

  typedef enum logic [15:0] {
    B_IDLE  = 16'h0001,
    B_WMUL  = 16'h0002,
    B_WGT   = 16'h0004,
    B_AVG   = 16'h0008,
    B_DIV2  = 16'h0010,
    B_SQX   = 16'h0020,
    B_SQZ   = 16'h0040,
    B_SQR   = 16'h0080,
    B_ARG   = 16'h0100,
    B_ROOT  = 16'h0200,
    B_ANORM = 16'h0400,
    B_AROT  = 16'h0800,
    B_PDP   = 16'h1000,
    B_PDD   = 16'h2000,
    B_PDS   = 16'h4000,
    B_OUT   = 16'h8000
  } bstate_t;

  bstate_t state_r, state_nxt;
  logic    out_valid_r;

  q_entry_t            e_r;
  logic signed [65:0]  prod_r, acc_r;
  logic [DEN_W-1:0]    weight_r, den_r;
  logic [DEN_W:0]      rem_r;
  logic [NUM_W-1:0]    quo_r;
  logic [94:0]         racc_r;
  logic                neg_r;
  logic [5:0]          cnt_r;
  logic signed [31:0]  refx_r;
  logic [63:0]         norm_r, v_r, r_r, bit_r;
  logic signed [35:0]  x_r, y_r;
  logic signed [19:0]  z_r;
  logic                which_r;
  logic signed [19:0]  refa_r, tilt_r;
  logic signed [31:0]  mc_r;
  logic signed [31:0]  out_mc_r;
  logic                out_en_r;
  logic signed [18:0]  out_ref_r, out_tilt_r;

  logic signed [32:0]  mul_a, mul_b;
  logic [DEN_W:0]      rem_s, rem_n;
  logic                div_ge;
  logic [NUM_W-1:0]    quo_n;
  logic [94:0]         racc_n;
  logic signed [NUM_W:0] q_signed;
  logic signed [SUM_W-1:0] sum_mag;
  logic [63:0]         s_t, r_n, arg;
  logic [31:0]         sq_cl;
  logic signed [35:0]  xs, ys, x_rot, y_rot;
  logic signed [19:0]  z_rot, z_cl;
  logic                x_small, y_small, a_zero;
  logic                a_fin;
  logic signed [19:0]  a_z;
  logic signed [20:0]  ang_diff;
  logic signed [65:0]  u_full, u_lim;

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      B_WMUL: begin
        mul_a = $signed({2'b00, cfg.total_mass});
        mul_b = $signed({13'd0, G_Q16});
      end
      B_AVG: begin
        mul_a = $signed({12'd0, cnt_r[1] ? sum_mag[41:21] : sum_mag[20:0]});
        mul_b = cnt_r[0] ? $signed({6'd0, RECIP_HI}) : $signed({7'd0, RECIP_LO});
      end
      B_SQX: begin
        mul_a = 33'(e_r.com_x);
        mul_b = 33'(e_r.com_x);
      end
      B_SQZ: begin
        mul_a = 33'(e_r.com_z);
        mul_b = 33'(e_r.com_z);
      end
      B_SQR: begin
        mul_a = 33'(refx_r);
        mul_b = 33'(refx_r);
      end
      B_PDP: begin
        mul_a = $signed({2'b00, cfg.gain_kp});
        mul_b = 33'(ang_diff);
      end
      B_PDD: begin
        mul_a = $signed({2'b00, cfg.gain_kd});
        mul_b = 33'(e_r.pitch_rate);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rem_s    = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    div_ge   = rem_s >= {1'b0, den_r};
    rem_n    = div_ge ? rem_s - {1'b0, den_r} : rem_s;
    quo_n    = {quo_r[NUM_W-2:0], div_ge};
    q_signed = neg_r ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
    sum_mag  = e_r.torque_sum[SUM_W-1] ? -e_r.torque_sum : e_r.torque_sum;

    unique case (cnt_r)
      6'd1:    racc_n = 95'(prod_r[47:0]);
      6'd2:    racc_n = racc_r + (95'(prod_r[47:0]) << 26);
      6'd3:    racc_n = racc_r + (95'(prod_r[47:0]) << 21);
      6'd4:    racc_n = racc_r + (95'(prod_r[47:0]) << 47);
      default: racc_n = '0;
    endcase

    s_t   = r_r + bit_r;
    r_n   = (v_r >= s_t) ? (r_r >> 1) + bit_r : (r_r >> 1);
    sq_cl = (r_n > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_n[31:0];
    arg   = (norm_r > prod_r[63:0]) ? norm_r - prod_r[63:0] : 64'd0;

    xs = x_r >>> cnt_r[4:0];
    ys = y_r >>> cnt_r[4:0];
    if (y_r > 36'sd0) begin
      x_rot = x_r + ys;
      y_rot = y_r - xs;
      z_rot = z_r + $signed({3'b000, atan_entry(cnt_r[4:0])});
    end else begin
      x_rot = x_r - ys;
      y_rot = y_r + xs;
      z_rot = z_r - $signed({3'b000, atan_entry(cnt_r[4:0])});
    end
    if (z_rot > PI_Q16) begin
      z_cl = PI_Q16;
    end else if (z_rot < -PI_Q16) begin
      z_cl = -PI_Q16;
    end else begin
      z_cl = z_rot;
    end
    x_small = (x_r > -NORM_LIM) && (x_r < NORM_LIM);
    y_small = (y_r > -NORM_LIM) && (y_r < NORM_LIM);
    a_zero  = (x_r == 36'sd0) && (y_r == 36'sd0);
    a_fin   = ((state_r == B_ANORM) && a_zero) || ((state_r == B_AROT) && (cnt_r == ROT_LAST));
    a_z     = (state_r == B_AROT) ? z_cl : 20'sd0;

    ang_diff = 21'(tilt_r) - 21'(refa_r);
    u_full   = (acc_r + prod_r) >>> 16;
    u_lim    = $signed({35'd0, cfg.drive_limit});
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_WMUL;
      B_WMUL:  state_nxt = B_WGT;
      B_WGT:   state_nxt = B_AVG;
      B_AVG: begin
        if (cnt_r == AVG_LAST) begin
          state_nxt = (e_r.respond && (weight_r != '0)) ? B_DIV2 : B_SQX;
        end
      end
      B_DIV2:  if (cnt_r == DIV_LAST) state_nxt = B_SQX;
      B_SQX:   state_nxt = B_SQZ;
      B_SQZ:   state_nxt = B_SQR;
      B_SQR:   state_nxt = B_ARG;
      B_ARG:   state_nxt = B_ROOT;
      B_ROOT:  if (cnt_r == ROOT_LAST) state_nxt = B_ANORM;
      B_ANORM: begin
        if (a_fin) begin
          state_nxt = which_r ? B_PDP : B_ANORM;
        end else if (!(x_small && y_small)) begin
          state_nxt = B_AROT;
        end
      end
      B_AROT:  if (a_fin) state_nxt = which_r ? B_PDP : B_ANORM;
      B_PDP:   state_nxt = B_PDD;
      B_PDD:   state_nxt = B_PDS;
      B_PDS:   state_nxt = B_OUT;
      B_OUT:   if (!out_valid_r || out_ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == B_OUT) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (a_fin) begin
      if (which_r) begin
        tilt_r <= a_z;
      end else begin
        refa_r  <= a_z;
        x_r     <= 36'(e_r.com_z);
        y_r     <= 36'(e_r.com_x);
        which_r <= 1'b1;
      end
    end
    unique case (state_r)
      B_IDLE: e_r <= q_data;
      B_WGT: begin
        weight_r <= prod_r[DEN_W+15:16];
        neg_r    <= e_r.torque_sum[SUM_W-1];
        cnt_r    <= '0;
      end
      B_AVG: begin
        racc_r <= racc_n;
        if (cnt_r == AVG_LAST) begin
          refx_r <= 32'sd0;
          quo_r  <= {racc_n[83:52], 16'd0};
          rem_r  <= '0;
          den_r  <= weight_r;
          cnt_r  <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      B_DIV2: begin
        rem_r <= rem_n;
        quo_r <= quo_n;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) refx_r <= sat32(66'(q_signed));
      end
      B_SQZ: norm_r <= prod_r[63:0];
      B_SQR: norm_r <= norm_r + prod_r[63:0];
      B_ARG: begin
        v_r   <= arg;
        r_r   <= '0;
        bit_r <= 64'h4000_0000_0000_0000;
        cnt_r <= '0;
      end
      B_ROOT: begin
        if (v_r >= s_t) v_r <= v_r - s_t;
        r_r   <= r_n;
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ROOT_LAST) begin
          x_r     <= 36'($signed({1'b0, sq_cl}));
          y_r     <= -36'(refx_r);
          which_r <= 1'b0;
        end
      end
      B_ANORM: begin
        if (!a_zero) begin
          if (x_small && y_small) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            cnt_r <= '0;
            if (x_r < 36'sd0) begin
              if (y_r >= 36'sd0) begin
                x_r <= y_r;
                y_r <= -x_r;
                z_r <= HALF_PI_Q16;
              end else begin
                x_r <= -y_r;
                y_r <= x_r;
                z_r <= -HALF_PI_Q16;
              end
            end else begin
              z_r <= 20'sd0;
            end
          end
        end
      end
      B_AROT: begin
        if (!a_fin) begin
          x_r <= x_rot;
          y_r <= y_rot;
        end
        z_r   <= z_rot;
        cnt_r <= cnt_r + 1'b1;
      end
      B_PDD: acc_r <= prod_r;
      B_PDS: begin
        if (u_full > u_lim) begin
          mc_r <= u_lim[31:0];
        end else if (u_full < -u_lim) begin
          mc_r <= 32'(-u_lim);
        end else begin
          mc_r <= u_full[31:0];
        end
      end
      B_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_mc_r   <= mc_r;
          out_en_r   <= e_r.balance;
          out_ref_r  <= refa_r[18:0];
          out_tilt_r <= tilt_r[18:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign motor_current   = out_mc_r;
  assign drive_enable    = out_en_r;
  assign reference_angle = out_ref_r;
  assign tilt_angle      = out_tilt_r;

endmodule

`default_nettype wire

>>> rtl/core/force_compensated_balance_pd.sv
// Top level of the force compensated balance PD controller with its register file.
//
//   Channel   Direction  Handshake                 Payload
//   in_*      slave      in_tvalid / in_tready     seven Q16.16 samples, respond and balance
//   out_*     master     out_tvalid / out_tready   command, reference tilt, tilt, enable
//   cfg_*     slave      APB write setup + access  seven configuration registers
//
// Each item runs through the back end's sequencer: a reciprocal multiply for the average, a
// 48-step bit-serial division by the weight when respond is set and the weight is nonzero,
// a 32-step square root and two CORDIC passes of up to 29 scaling steps, one pre-rotation
// and 17 rotations.
// The front end takes the next item only after pushing the previous one into
// a two-entry queue, so input and output stall independently of each other.
// The torque history needs no clearing pass after reset; a fill flag masks unwritten entries.
`default_nettype none

module force_compensated_balance_pd #(
  parameter int AVG_WINDOW = fcb_pkg::AVG_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // force_x, force_z, gripper_x, gripper_z, com_x_raw, com_z_raw, pitch_rate
  input  logic [223:0]                    in_tdata,
  // respond, balance
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // motor_current, reference_angle, tilt_angle, zero padding
  output logic [71:0]                     out_tdata,
  // drive_enable
  output logic [0:0]                      out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fcb_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import fcb_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  q_entry_t push_data, pop_data;
  logic     q_push, q_full, q_pop, q_empty;
  logic signed [31:0] motor_current;
  logic signed [18:0] reference_angle, tilt_angle;
  logic               drive_enable;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_mass     <= 31'd9502720;
      cfg_r.force_deadband <= 31'd196608;
      cfg_r.gain_kp        <= 31'd16384000;
      cfg_r.gain_kd        <= 31'd2621440;
      cfg_r.drive_limit    <= 31'd1310720;
      cfg_r.wheel_radius   <= 31'd17302;
      cfg_r.com_x_offset   <= 32'sd793;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (reg_idx)
        REG_TOTAL_MASS:     cfg_r.total_mass     <= cfg_pwdata[30:0];
        REG_FORCE_DEADBAND: cfg_r.force_deadband <= cfg_pwdata[30:0];
        REG_GAIN_KP:        cfg_r.gain_kp        <= cfg_pwdata[30:0];
        REG_GAIN_KD:        cfg_r.gain_kd        <= cfg_pwdata[30:0];
        REG_DRIVE_LIMIT:    cfg_r.drive_limit    <= cfg_pwdata[30:0];
        REG_WHEEL_RADIUS:   cfg_r.wheel_radius   <= cfg_pwdata[30:0];
        REG_COM_X_OFFSET:   cfg_r.com_x_offset   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TOTAL_MASS:     cfg_prdata = {1'b0, cfg_r.total_mass};
      REG_FORCE_DEADBAND: cfg_prdata = {1'b0, cfg_r.force_deadband};
      REG_GAIN_KP:        cfg_prdata = {1'b0, cfg_r.gain_kp};
      REG_GAIN_KD:        cfg_prdata = {1'b0, cfg_r.gain_kd};
      REG_DRIVE_LIMIT:    cfg_prdata = {1'b0, cfg_r.drive_limit};
      REG_WHEEL_RADIUS:   cfg_prdata = {1'b0, cfg_r.wheel_radius};
      REG_COM_X_OFFSET:   cfg_prdata = cfg_r.com_x_offset;
      default:            cfg_prdata = 32'd0;
    endcase
  end

  fcb_front #(.AVG_WINDOW(AVG_WINDOW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .force_x    (in_tdata[31:0]),
    .force_z    (in_tdata[63:32]),
    .gripper_x  (in_tdata[95:64]),
    .gripper_z  (in_tdata[127:96]),
    .com_x_raw  (in_tdata[159:128]),
    .com_z_raw  (in_tdata[191:160]),
    .pitch_rate (in_tdata[223:192]),
    .respond    (in_tuser[0]),
    .balance    (in_tuser[1]),
    .q_push     (q_push),
    .q_data     (push_data),
    .q_full     (q_full)
  );

  fcb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  fcb_back #(.AVG_WINDOW(AVG_WINDOW)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_data          (pop_data),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .motor_current   (motor_current),
    .drive_enable    (drive_enable),
    .reference_angle (reference_angle),
    .tilt_angle      (tilt_angle)
  );

  assign out_tdata = {2'b00, tilt_angle, reference_angle, motor_current};
  assign out_tuser = drive_enable;

endmodule

`default_nettype wire

>>> rtl/core/fcb_checker.sv
// Port-level checker of the force compensated balance block and its bind statement.
`default_nettype none

module fcb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        cfg_pready
);

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("cfg_pready dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item withdrawn before it was taken");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result item shown right after reset");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("front end took two items in consecutive cycles");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[50:32]) <= 19'sd205887)
                && ($signed(out_tdata[50:32]) >= -19'sd205887)
                && ($signed(out_tdata[69:51]) <= 19'sd205887)
                && ($signed(out_tdata[69:51]) >= -19'sd205887))
    else $error("angle outside plus or minus pi");

endmodule

bind force_compensated_balance_pd fcb_checker u_fcb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

`default_nettype wire

>>> tb/tb_force_compensated_balance_pd.sv
// Self-checking testbench for the force compensated balance PD controller.
`default_nettype none

module tb_force_compensated_balance_pd;
  timeunit 1ns;
  timeprecision 1ps;
  import fcb_pkg::*;

  localparam int WINDOW     = 100;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 600;

  typedef struct {
    logic signed [31:0] force_x, force_z, gripper_x, gripper_z;
    logic signed [31:0] com_x_raw, com_z_raw, pitch_rate;
    logic respond, balance;
  } sample_t;

  typedef struct {
    logic signed [31:0] motor_current;
    logic               drive_enable;
    logic [18:0]        reference_angle, tilt_angle;
  } command_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [223:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  force_compensated_balance_pd DUT (.*);

  always #5 clk = ~clk;

  longint mass_q, deadband_q, kp_q, kd_q, limit_q, radius_q, offset_q;
  longint lever_hist[WINDOW];
  longint lever_sum;
  int hist_idx;
  command_t expected_cmds[$];
  int errors = 0;
  int rx_wait = 0, rx_hold = 0;
  bit hold_req = 0;
  bit tx_burst = 0, rx_burst = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z, t, xs, ys;
    longint tab[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
    z = 0;
    if (x == 0 && y == 0) return 0;
    while (abs64(x) < (64'sd1 << 29) && abs64(y) < (64'sd1 << 29)) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 102944;
      end else begin
        t = x; x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < 17; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + tab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - tab[i];
      end
    end
    if (z > 205887) z = 205887;
    if (z < -205887) z = -205887;
    return z;
  endfunction

  function automatic command_t balance_predict(sample_t s);
    command_t c;
    longint fx, fz, lever, torque, avg, weight, refx, cx, cz, sq, refa, tilt, u;
    longint unsigned norm, rsq, arg;
    fx = s.force_x;
    fz = s.force_z;
    if (abs64(fx) <= deadband_q) fx = 0;
    if (abs64(fz) <= deadband_q) fz = 0;
    lever = sat32(longint'(s.gripper_z) - radius_q);
    torque = sat32(((fx * lever) >>> 16) + ((fz * longint'(s.gripper_x)) >>> 16));
    lever_sum = lever_sum + torque - lever_hist[hist_idx];
    lever_hist[hist_idx] = torque;
    hist_idx = (hist_idx + 1) % WINDOW;
    avg = lever_sum / WINDOW;
    weight = (mass_q * 642908) >>> 16;
    refx = 0;
    if (s.respond && weight != 0) refx = sat32((avg * 65536) / weight);
    cx = sat32(longint'(s.com_x_raw) + offset_q);
    cz = sat32(longint'(s.com_z_raw) - radius_q);
    norm = longint'(cx * cx) + longint'(cz * cz);
    rsq = refx * refx;
    arg = (norm > rsq) ? norm - rsq : 0;
    sq = int_sqrt(arg);
    if (sq > 64'sd2147483647) sq = 64'sd2147483647;
    refa = cordic_angle(-refx, sq);
    tilt = cordic_angle(cx, cz);
    u = (kp_q * (tilt - refa) + kd_q * longint'(s.pitch_rate)) >>> 16;
    if (u > limit_q) u = limit_q;
    if (u < -limit_q) u = -limit_q;
    c.motor_current = u[31:0];
    c.drive_enable = s.balance;
    c.reference_angle = refa[18:0];
    c.tilt_angle = tilt[18:0];
    return c;
  endfunction

  task automatic report_error(string msg);
    errors++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk) begin
    command_t e;
    if (out_tvalid && out_tready) begin
      rx_wait = rx_burst ? 0 : $urandom_range(0, 17);
      if (expected_cmds.size() == 0) begin
        report_error("result with no item outstanding");
      end else begin
        e = expected_cmds.pop_front();
        if (out_tdata[31:0] !== e.motor_current)
          report_error($sformatf("motor_current %h exp %h", out_tdata[31:0], e.motor_current));
        if (out_tuser[0] !== e.drive_enable)
          report_error($sformatf("drive_enable %b exp %b", out_tuser[0], e.drive_enable));
        if (out_tdata[50:32] !== e.reference_angle)
          report_error($sformatf("reference_angle %h exp %h", out_tdata[50:32],
                                 e.reference_angle));
        if (out_tdata[69:51] !== e.tilt_angle)
          report_error($sformatf("tilt_angle %h exp %h", out_tdata[69:51], e.tilt_angle));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      rx_hold = HOLD_LEN;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable) || !rst_n)
        idle = 0;
      else
        idle++;
    end
    $display("force_compensated_balance_pd verification failed");
    $finish;
  end

  task automatic send_sample(sample_t s);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = {s.pitch_rate, s.com_z_raw, s.com_x_raw, s.gripper_z, s.gripper_x,
                s.force_z, s.force_x};
    in_tuser = {s.balance, s.respond};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_cmds = {expected_cmds, balance_predict(s)};
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (260) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = CFG_ADDR_W'(idx) << 2;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_TOTAL_MASS:     mass_q = value[30:0];
      REG_FORCE_DEADBAND: deadband_q = value[30:0];
      REG_GAIN_KP:        kp_q = value[30:0];
      REG_GAIN_KD:        kd_q = value[30:0];
      REG_DRIVE_LIMIT:    limit_q = value[30:0];
      REG_WHEEL_RADIUS:   radius_q = value[30:0];
      REG_COM_X_OFFSET:   offset_q = longint'(signed'(value));
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] m;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 0;
      default: begin
        m = $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(4, 30);
        return $urandom_range(0, 1) ? -m : m;
      end
    endcase
  endfunction

  // Physically plausible ticks with occasional out-of-range fields.
  function automatic sample_t pick_sample();
    sample_t s;
    bit noisy;
    noisy = ($urandom_range(0, 5) == 0);
    s.force_x = noisy ? pick_value() : $signed($urandom_range(0, 6553600)) - 3276800;
    s.force_z = noisy ? pick_value() : $signed($urandom_range(0, 6553600)) - 3276800;
    s.gripper_x = noisy ? pick_value() : $signed($urandom_range(0, 131072)) - 65536;
    s.gripper_z = noisy ? pick_value() : $signed($urandom_range(0, 98304));
    s.com_x_raw = noisy ? pick_value() : $signed($urandom_range(0, 26214)) - 13107;
    s.com_z_raw = noisy ? pick_value() : $signed($urandom_range(13107, 52428));
    s.pitch_rate = noisy ? pick_value() : $signed($urandom_range(0, 262144)) - 131072;
    s.respond = $urandom_range(0, 3) != 0;
    s.balance = $urandom_range(0, 1);
    return s;
  endfunction

  function automatic sample_t make_sample(logic [31:0] fx, fz, gx, gz, cx, cz, rate,
                                          logic resp, bal);
    sample_t s;
    s.force_x = fx; s.force_z = fz; s.gripper_x = gx; s.gripper_z = gz;
    s.com_x_raw = cx; s.com_z_raw = cz; s.pitch_rate = rate;
    s.respond = resp; s.balance = bal;
    return s;
  endfunction

  task automatic test_directed();
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(make_sample('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1,
                            1, 1));
    send_sample(make_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1));
    send_sample(make_sample(196608, -196608, 65536, 65536, 0, 32768, 0, 1, 1));
    send_sample(make_sample(196609, -196609, 65536, 65536, 0, 32768, 0, 1, 0));
    // Both tilt inputs zero after the offset and wheel radius corrections.
    send_sample(make_sample(0, 0, 0, 0, -793, 17302, 100, 1, 1));
    send_sample(make_sample(0, 0, 0, 0, -65536, -65536, 0, 0, 1));
    send_sample(make_sample(0, 0, 0, 0, 65536, -65536, 0, 0, 1));
    send_sample(make_sample(0, 0, 0, 0, -65536, 65536, -65536, 0, 0));
    // Large lever torque against a tiny COM drives the root argument negative.
    for (int i = 0; i < 6; i++)
      send_sample(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              0, 17400, 0, 1, 1));
    send_sample(make_sample(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 17400, 0, 0, 1));
    for (int i = 0; i < 4; i++)
      send_sample(make_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                              1000, 18000, 32'h7FFF_FFFF, 1, i[0]));
    send_sample(make_sample(-3276800, 3276800, -65536, 0, 6553, 32768, 655360, 1, 1));
    drain_results();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 40) == 0) tx_burst = ~tx_burst;
      if ($urandom_range(0, 40) == 0) rx_burst = ~rx_burst;
      send_sample(pick_sample());
    end
    drain_results();
  endtask

  task automatic test_register_settings();
    logic [31:0] v;
    write_register(REG_TOTAL_MASS, 32'hFFFF_FFFF);
    write_register(REG_FORCE_DEADBAND, 32'h7FFF_FFFF);
    write_register(REG_GAIN_KP, 32'h7FFF_FFFF);
    write_register(REG_GAIN_KD, 32'h7FFF_FFFF);
    write_register(REG_DRIVE_LIMIT, 32'h7FFF_FFFF);
    write_register(REG_WHEEL_RADIUS, 32'h7FFF_FFFF);
    write_register(REG_COM_X_OFFSET, 32'h7FFF_FFFF);
    test_random(150);
    // Zero mass leaves no weight term, so the reference offset stays zero.
    write_register(REG_TOTAL_MASS, 0);
    write_register(REG_FORCE_DEADBAND, 0);
    write_register(REG_GAIN_KP, 0);
    write_register(REG_GAIN_KD, 0);
    write_register(REG_DRIVE_LIMIT, 0);
    write_register(REG_WHEEL_RADIUS, 0);
    write_register(REG_COM_X_OFFSET, 32'h8000_0000);
    test_random(120);
    // A very light robot saturates the reference offset.
    write_register(REG_TOTAL_MASS, 1);
    write_register(REG_DRIVE_LIMIT, 32'h7FFF_FFFF);
    write_register(REG_GAIN_KP, 16384000);
    write_register(REG_COM_X_OFFSET, 0);
    test_random(120);
    for (int k = 0; k < 3; k++) begin
      write_register(REG_TOTAL_MASS, $urandom_range(65536, 32'h0FFF_FFFF));
      write_register(REG_FORCE_DEADBAND, $urandom_range(0, 655360));
      write_register(REG_GAIN_KP, $urandom_range(0, 65536000));
      write_register(REG_GAIN_KD, $urandom_range(0, 6553600));
      write_register(REG_DRIVE_LIMIT, $urandom_range(0, 6553600));
      write_register(REG_WHEEL_RADIUS, $urandom_range(0, 65536));
      v = $urandom_range(0, 13107);
      write_register(REG_COM_X_OFFSET, $urandom_range(0, 1) ? -v : v);
      // Address past the register list must be ignored.
      write_register(reg_idx_t'(7), $urandom);
      test_random(130);
    end
  endtask

  task automatic test_output_stall();
    @(posedge clk);
    hold_req = 1;
    tx_burst = 1;
    for (int i = 0; i < 12; i++) send_sample(pick_sample());
    tx_burst = 0;
    drain_results();
  endtask

  task automatic test_sender_pause();
    for (int k = 0; k < 5; k++) begin
      for (int i = 0; i < 4; i++) send_sample(pick_sample());
      drain_results();
    end
  endtask

  initial begin
    mass_q = 9502720; deadband_q = 196608; kp_q = 16384000; kd_q = 2621440;
    limit_q = 1310720; radius_q = 17302; offset_q = 793;
    foreach (lever_hist[i]) lever_hist[i] = 0;
    lever_sum = 0;
    hist_idx = 1;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(600);
    test_output_stall();
    test_sender_pause();
    test_register_settings();
    test_random(200);
    if (errors == 0) begin
      $display("force_compensated_balance_pd verification clean");
    end else begin
      $display("force_compensated_balance_pd verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
